[hw/rtl/smdf_pkg.sv]
// Shared types and constants for the serial mode demux framer.
// Used by smdf_cfg, smdf_engine and serial_mode_demux_framer; no dependencies.
package smdf_pkg;

   localparam int BUF_BYTES_DEF       = 512;
   localparam int HEADER_BYTES        = 7;
   localparam int MIN_FRAME_BYTES_DEF = 8;

   localparam int POS_W   = 10;
   localparam int TICK_W  = 16;
   localparam int LEN_W   = 16;
   localparam int FULL_W  = LEN_W + 1;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 16;

   localparam logic [POS_W-1:0] LEN_LO_POS = POS_W'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] LEN_HI_POS = POS_W'(HEADER_BYTES);

   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_END = 8'h7F;
   localparam logic [7:0] ASCII_LF = 8'h0A;
   localparam logic [7:0] ASCII_CR = 8'h0D;

   localparam logic [CSR_A_W-1:0] CSR_MAGIC      = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FRAME_TOUT = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_LINE_TOUT  = 2'd2;

   localparam logic [7:0]        MAGIC_RST      = 8'd170;
   localparam logic [TICK_W-1:0] FRAME_TOUT_RST = 16'd500;
   localparam logic [TICK_W-1:0] LINE_TOUT_RST  = 16'd200;

   localparam logic [1:0] EV_DATA = 2'd0;
   localparam logic [1:0] EV_LAST = 2'd1;
   localparam logic [1:0] EV_END  = 2'd2;
   localparam logic [1:0] EV_DROP = 2'd3;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_RAW   = 2'd2;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic [7:0]        magic_byte;
      logic [TICK_W-1:0] frame_timeout;
      logic [TICK_W-1:0] line_timeout;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       event_res;
      logic [1:0]       kind;
      logic [7:0]       out_byte;
      logic [POS_W-1:0] position;
   } res_type;

endpackage

[hw/rtl/smdf_cfg.sv]
// Configuration registers of the serial mode demux framer.
// Depends on smdf_pkg.
module smdf_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [smdf_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [smdf_pkg::CSR_D_W-1:0]   csr_wdata,
   output smdf_pkg::cfg_type              cfg
);

   smdf_pkg::cfg_type cfg_ff;
   smdf_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            smdf_pkg::CSR_MAGIC:      cfg_in.magic_byte    = csr_wdata[7:0];
            smdf_pkg::CSR_FRAME_TOUT: cfg_in.frame_timeout = csr_wdata;
            smdf_pkg::CSR_LINE_TOUT:  cfg_in.line_timeout  = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_byte    <= smdf_pkg::MAGIC_RST;
         cfg_ff.frame_timeout <= smdf_pkg::FRAME_TOUT_RST;
         cfg_ff.line_timeout  <= smdf_pkg::LINE_TOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/smdf_engine.sv]
// Message state and per-request classification for the serial mode demux framer.
// Depends on smdf_pkg; fed by the top level's request register.
module smdf_engine #(
   parameter int BUF_BYTES       = smdf_pkg::BUF_BYTES_DEF,
   parameter int MIN_FRAME_BYTES = smdf_pkg::MIN_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  smdf_pkg::cfg_type cfg,
   input  logic              step,
   input  logic              func,
   input  logic [7:0]        rx_byte,
   output logic              res_vld,
   output smdf_pkg::res_type res
);

   localparam logic [smdf_pkg::POS_W-1:0]  BufLim = smdf_pkg::POS_W'(BUF_BYTES);
   localparam logic [smdf_pkg::POS_W-1:0]  MinLim = smdf_pkg::POS_W'(MIN_FRAME_BYTES);
   localparam logic [smdf_pkg::FULL_W-1:0] FullExtra =
      smdf_pkg::FULL_W'(smdf_pkg::HEADER_BYTES + 1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_FRAME,
      MODE_LINE
   } mode_type;

   mode_type                        mode_ff, mode_in;
   logic [smdf_pkg::POS_W-1:0]      cnt_ff, cnt_in;
   logic [smdf_pkg::LEN_W-1:0]      pay_ff, pay_in;
   logic [smdf_pkg::TICK_W-1:0]     ticks_ff, ticks_in;

   logic [smdf_pkg::TICK_W-1:0]     ticks_inc;
   logic [smdf_pkg::TICK_W-1:0]     limit;
   logic [smdf_pkg::POS_W-1:0]      cnt_nxt;
   logic [smdf_pkg::LEN_W-1:0]      pay_nxt;
   logic [smdf_pkg::FULL_W-1:0]     full_len;
   logic [1:0]                      cur_kind;
   logic                            is_eol;
   logic                            is_print;

   always_comb begin
      ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
      limit     = (mode_ff == MODE_FRAME) ? cfg.frame_timeout : cfg.line_timeout;
      cur_kind  = (mode_ff == MODE_FRAME) ? smdf_pkg::KIND_FRAME : smdf_pkg::KIND_LINE;
      is_eol    = (rx_byte == smdf_pkg::ASCII_LF) || (rx_byte == smdf_pkg::ASCII_CR);
      is_print  = (rx_byte >= smdf_pkg::PRINT_LO) && (rx_byte < smdf_pkg::PRINT_END);
      cnt_nxt   = cnt_ff + 1'b1;
      if (cnt_nxt == smdf_pkg::LEN_LO_POS) begin
         pay_nxt = {8'd0, rx_byte};
      end else if (cnt_nxt == smdf_pkg::LEN_HI_POS) begin
         pay_nxt = {rx_byte, pay_ff[7:0]};
      end else begin
         pay_nxt = pay_ff;
      end
      full_len = FullExtra + smdf_pkg::FULL_W'(pay_nxt);

      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      pay_in   = pay_ff;
      ticks_in = ticks_ff;
      res_vld  = 1'b0;
      res      = '0;

      if (func == smdf_pkg::FUNC_TICK) begin
         if (mode_ff != MODE_IDLE) begin
            if (ticks_inc > limit) begin
               res_vld   = 1'b1;
               res       = '{smdf_pkg::EV_DROP, cur_kind, 8'd0, cnt_ff};
               mode_in   = MODE_IDLE;
               cnt_in    = '0;
               pay_in    = '0;
               ticks_in  = '0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
      end else if (mode_ff == MODE_IDLE) begin
         if (rx_byte == cfg.magic_byte) begin
            res_vld  = 1'b1;
            res      = '{smdf_pkg::EV_DATA, smdf_pkg::KIND_FRAME, rx_byte, 10'd1};
            mode_in  = MODE_FRAME;
            cnt_in   = 10'd1;
            ticks_in = '0;
         end else if (is_print) begin
            res_vld  = 1'b1;
            res      = '{smdf_pkg::EV_DATA, smdf_pkg::KIND_LINE, rx_byte, 10'd1};
            mode_in  = MODE_LINE;
            cnt_in   = 10'd1;
            ticks_in = '0;
         end else if (!is_eol) begin
            res_vld = 1'b1;
            res     = '{smdf_pkg::EV_LAST, smdf_pkg::KIND_RAW, rx_byte, 10'd1};
         end
      end else if (cnt_ff >= BufLim) begin
         res_vld  = 1'b1;
         res      = '{smdf_pkg::EV_DROP, cur_kind, 8'd0, cnt_ff};
         mode_in  = MODE_IDLE;
         cnt_in   = '0;
         pay_in   = '0;
         ticks_in = '0;
      end else if (mode_ff == MODE_LINE) begin
         res_vld = 1'b1;
         if (is_eol) begin
            res      = '{smdf_pkg::EV_END, smdf_pkg::KIND_LINE, 8'd0, cnt_nxt};
            mode_in  = MODE_IDLE;
            cnt_in   = '0;
            pay_in   = '0;
            ticks_in = '0;
         end else begin
            res    = '{smdf_pkg::EV_DATA, smdf_pkg::KIND_LINE, rx_byte, cnt_nxt};
            cnt_in = cnt_nxt;
         end
      end else begin
         res_vld = 1'b1;
         res     = '{smdf_pkg::EV_DATA, smdf_pkg::KIND_FRAME, rx_byte, cnt_nxt};
         cnt_in  = cnt_nxt;
         pay_in  = pay_nxt;
         if (cnt_nxt >= MinLim) begin
            if (full_len > smdf_pkg::FULL_W'(BufLim)) begin
               res      = '{smdf_pkg::EV_DROP, smdf_pkg::KIND_FRAME, 8'd0, cnt_nxt};
               mode_in  = MODE_IDLE;
               cnt_in   = '0;
               pay_in   = '0;
               ticks_in = '0;
            end else if (smdf_pkg::FULL_W'(cnt_nxt) >= full_len) begin
               res      = '{smdf_pkg::EV_LAST, smdf_pkg::KIND_FRAME, rx_byte, cnt_nxt};
               mode_in  = MODE_IDLE;
               cnt_in   = '0;
               pay_in   = '0;
               ticks_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cnt_ff   <= '0;
         pay_ff   <= '0;
         ticks_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         pay_ff   <= pay_in;
         ticks_ff <= ticks_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= BufLim)
      else $error("byte count beyond buffer size");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (cnt_ff == '0 && pay_ff == '0 && ticks_ff == '0))
      else $error("idle with stale message state");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (cnt_ff != '0))
      else $error("open message without bytes");

   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (step && res_vld && (res.event_res == smdf_pkg::EV_DROP
         || res.event_res == smdf_pkg::EV_END)) |=> (mode_ff == MODE_IDLE))
      else $error("message not closed after discard or line end");

endmodule

[hw/rtl/serial_mode_demux_framer.sv]
// Top level of the serial mode demux framer: request register, engine, response register.
// Depends on smdf_pkg, smdf_cfg and smdf_engine.
//
//   channel | direction | tdata                         | tuser
//   req     | in        | rx_byte[7:0]                  | func
//   rsp     | out       | out_byte[7:0], position[17:8] | event_res[1:0], kind[3:2]
//   csr     | in        | write only: we, addr, wdata   | -
//
// One request per cycle while the response is not stalled; requests pass the request
// register, then the response register. Ticks and requests with no response use a slot.
// Reset is synchronous and returns to idle with register defaults.
// A stalled response holds and stops the engine; the request register holds one
// request and keeps req_tready low until the response drains.
module serial_mode_demux_framer #(
   parameter int BUF_BYTES       = smdf_pkg::BUF_BYTES_DEF,
   parameter int MIN_FRAME_BYTES = smdf_pkg::MIN_FRAME_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // rx_byte
   input  logic                          req_tuser,   // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // out_byte, position, zero pad
   output logic [3:0]                    rsp_tuser,   // event_res, kind
   input  logic                          csr_we,
   input  logic [smdf_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [smdf_pkg::CSR_D_W-1:0]  csr_wdata
);

   smdf_pkg::cfg_type cfg;
   smdf_pkg::res_type eng_res;
   smdf_pkg::res_type rsp_res_ff;
   logic              eng_vld;
   logic              req_vld_ff;
   logic              req_func_ff;
   logic [7:0]        req_byte_ff;
   logic              rsp_vld_ff;
   logic              adv;

   assign adv        = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || adv;

   smdf_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smdf_engine #(
      .BUF_BYTES       (BUF_BYTES),
      .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (adv),
      .func    (req_func_ff),
      .rx_byte (req_byte_ff),
      .res_vld (eng_vld),
      .res     (eng_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_vld_ff <= req_tvalid;
         end
         if (adv && eng_vld) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_func_ff <= req_tuser;
         req_byte_ff <= req_tdata;
      end
      if (adv && eng_vld) begin
         rsp_res_ff <= eng_res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_res_ff.position, rsp_res_ff.out_byte};
   assign rsp_tuser  = {rsp_res_ff.kind, rsp_res_ff.event_res};

endmodule
